>>> rtl/bpf28_pkg.sv
// ----------------------------------------------------------------------------
// bpf28_pkg
// Widths, tap count and the fixed symmetric bandpass coefficients used by
// the 28-tap Q15 FIR core.
// ----------------------------------------------------------------------------
package bpf28_pkg;

	localparam int TAPS     = 28;
	localparam int HALF     = TAPS / 2;
	localparam int SMP_W    = 16;
	localparam int COEF_W   = 14;
	localparam int PRE_W    = SMP_W + 1;
	localparam int PROD_W   = PRE_W + COEF_W;
	localparam int ACC_W    = 32;
	localparam int FRAC_W   = 15;
	localparam int GRP_SIZE = 4;
	localparam int NGRP     = (HALF + GRP_SIZE - 1) / GRP_SIZE;

	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PRE_W-1:0]  pre_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// First half of the taps; the second half mirrors it.
	localparam coef_t COEF [HALF] = '{
		-14'sd29,   14'sd20,   14'sd90,    14'sd155,  14'sd119,
		-14'sd122,  -14'sd565, -14'sd999,  -14'sd1035, -14'sd284,
		14'sd1387,  14'sd3677, 14'sd5906,  14'sd7284
	};

	localparam sample_t SAT_MAX = sample_t'(16'sh7fff);
	localparam sample_t SAT_MIN = sample_t'(16'sh8000);

endpackage

>>> rtl/bandpass_fir_28tap_q15_core.sv
// ----------------------------------------------------------------------------
// bandpass_fir_28tap_q15_core
// Fixed 28-tap symmetric bandpass FIR on Q15 samples with exact accumulation,
// arithmetic shift by 15 and saturation to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis group: tdata carries one Q15 sample,
//   tuser carries the frame start flag. A word with frame start set clears
//   the sample history before its own sample is used.
//   Each input word gives exactly one output word on the m_axis group,
//   carrying the filtered Q15 sample.
//   Throughput is one word per clock while m_axis_tready is high. A
//   word's result reaches m_axis through an input register, a stage
//   of pre-adds and constant multiplies (the taps are folded in pairs), a
//   stage of partial sums, and the output register with shift and saturation.
//   When the receiver stalls, the pipeline stages fill up and s_axis_tready
//   drops only when all four stages hold a word; the output word is held.
//   Reset clears all valid flags and the sample history to zero.
// ----------------------------------------------------------------------------
module bandpass_fir_28tap_q15_core #(
	parameter int TAPS = bpf28_pkg::TAPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic [0:0]  s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] filtered_sample
);

	localparam int HALF = TAPS / 2;
	localparam int HIST = TAPS - 1;
	localparam int NGRP = (HALF + bpf28_pkg::GRP_SIZE - 1) / bpf28_pkg::GRP_SIZE;

	// Pipeline handshake: a stage may load when it is empty or drains.
	logic ld1, ld2, ld3, ldo;
	logic v1_s1, v2_s2, v3_s3, vo_q;

	assign ldo = !vo_q || m_axis_tready;
	assign ld3 = !v3_s3 || ldo;
	assign ld2 = !v2_s2 || ld3;
	assign ld1 = !v1_s1 || ld2;
	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			if (ld1) v1_s1 <= s_axis_tvalid;
			if (ld2) v2_s2 <= v1_s1;
			if (ld3) v3_s3 <= v2_s2;
			if (ldo) vo_q  <= v3_s3;
		end
	end

	// Input register.
	bpf28_pkg::sample_t sample_s1;
	logic               frame_s1;

	always_ff @(posedge clk) begin
		if (ld1 && s_axis_tvalid) begin
			sample_s1 <= bpf28_pkg::sample_t'(s_axis_tdata);
			frame_s1  <= s_axis_tuser[0];
		end
	end

	// Sample history, x[n-1] in entry 0.
	bpf28_pkg::sample_t hist_q [HIST];
	logic               adv1;

	assign adv1 = v1_s1 && ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST; k++) hist_q[k] <= '0;
		end else if (adv1) begin
			hist_q[0] <= sample_s1;
			for (int k = 1; k < HIST; k++) begin
				hist_q[k] <= frame_s1 ? '0 : hist_q[k-1];
			end
		end
	end

	// Tap window with the frame clear applied, then folded pre-adds.
	bpf28_pkg::sample_t win [TAPS];
	bpf28_pkg::pre_t    pre [HALF];
	bpf28_pkg::prod_t   prod_s2 [HALF];

	always_comb begin
		win[0] = sample_s1;
		for (int k = 1; k < TAPS; k++) begin
			win[k] = frame_s1 ? '0 : hist_q[k-1];
		end
		for (int i = 0; i < HALF; i++) begin
			pre[i] = {win[i][bpf28_pkg::SMP_W-1], win[i]}
			       + {win[TAPS-1-i][bpf28_pkg::SMP_W-1], win[TAPS-1-i]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < HALF; i++) begin
				prod_s2[i] <= pre[i] * bpf28_pkg::COEF[i];
			end
		end
	end

	// Partial sums over small groups of products.
	bpf28_pkg::acc_t psum [NGRP];
	bpf28_pkg::acc_t psum_s3 [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) psum[g] = '0;
		for (int i = 0; i < HALF; i++) begin
			psum[i / bpf28_pkg::GRP_SIZE] = psum[i / bpf28_pkg::GRP_SIZE]
			                              + bpf28_pkg::acc_t'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (v2_s2 && ld3) begin
			for (int g = 0; g < NGRP; g++) psum_s3[g] <= psum[g];
		end
	end

	// Final sum, floor shift by 15 and saturation.
	bpf28_pkg::acc_t    acc;
	bpf28_pkg::acc_t    shifted;
	bpf28_pkg::sample_t sat;
	bpf28_pkg::sample_t out_q;

	always_comb begin
		acc = '0;
		for (int g = 0; g < NGRP; g++) acc = acc + psum_s3[g];
		shifted = acc >>> bpf28_pkg::FRAC_W;
		if (shifted > bpf28_pkg::acc_t'(bpf28_pkg::SAT_MAX)) begin
			sat = bpf28_pkg::SAT_MAX;
		end else if (shifted < bpf28_pkg::acc_t'(bpf28_pkg::SAT_MIN)) begin
			sat = bpf28_pkg::SAT_MIN;
		end else begin
			sat = shifted[bpf28_pkg::SMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (v3_s3 && ldo) out_q <= sat;
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = out_q;

	// An empty output register never blocks the input.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vo_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A frame start leaves only the new sample in the history.
	a_frame_clears_history: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && frame_s1) |=> (hist_q[1] == '0 && hist_q[HIST-1] == '0))
		else $error("history not cleared on frame start");

	// A word leaving the last stage lands in the output register.
	a_stage3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && ldo) |=> vo_q)
		else $error("word lost between stage 3 and output");

endmodule
